// ===== hw/rtl/tof_pid_pkg.sv =====
// package: widths, constants, register map and payload types of the tof pid block
`timescale 1ns / 1ps

package tof_pid_pkg;

  localparam int unsigned NUM_HYPOTHESES_DEF = 5;
  localparam int unsigned MASS_COUNT = 5;

  localparam int unsigned POS_W  = 21;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned RES_W  = 10;
  localparam int unsigned TIME_W = 20;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned P_W    = 18;
  localparam int unsigned PK_W   = 28;
  localparam int unsigned PK2_W  = 56;
  localparam int unsigned E_W    = 28;
  localparam int unsigned T0_W   = 33;
  localparam int unsigned TOF4_W = 24;
  localparam int unsigned RES4_W = 14;
  localparam int unsigned Q4_W   = 29;
  localparam int unsigned R16_W  = 26;
  localparam int unsigned M2_W   = 40;
  localparam int unsigned R2_W   = 42;
  localparam int unsigned DIV_W  = 61;
  localparam int unsigned MASK_W = 5;

  // 2^32 / (29.9792458 units per ps), rounded
  localparam logic [27:0] INV_C_Q32 = 28'd143264688;
  localparam logic [9:0]  PK_SCALE  = 10'd1000;

  typedef enum logic [2:0] {
    REG_BARREL_RADIUS = 3'd0,
    REG_BARREL_HALF   = 3'd1,
    REG_DISC_INNER    = 3'd2,
    REG_DISC_OUTER    = 3'd3,
    REG_DISC_Z        = 3'd4,
    REG_TIME_RES      = 3'd5
  } tof_reg_e;

  typedef struct packed {
    logic [POS_W-1:0]  x_outer;
    logic [POS_W-1:0]  y_outer;
    logic [POS_W-1:0]  z_outer;
    logic [TIME_W-1:0] hit_time;
    logic [LEN_W-1:0]  path_length;
    logic [P_W-1:0]    momentum;
    logic [P_W-1:0]    momentum_error;
  } tof_in_t;

  typedef struct packed {
    logic              has_hit;
    logic [MASK_W-1:0] pid_mask;
  } tof_out_t;

  // per-track context handed to every hypothesis lane
  typedef struct packed {
    logic [PK_W-1:0]   pk;
    logic [T0_W-1:0]   t0;
    logic [P_W-1:0]    p;
    logic [P_W-1:0]    ep;
    logic [TOF4_W-1:0] tof4;
    logic [RES4_W-1:0] res4;
    logic              hit;
    logic              gate;
  } tof_ctx_t;

  // squared mass in keV^2
  function automatic logic [M2_W-1:0] mass_sq(input int unsigned idx);
    logic [19:0] m;
    unique case (idx)
      0:       m = 20'd511;
      1:       m = 20'd105658;
      2:       m = 20'd139570;
      3:       m = 20'd493677;
      default: m = 20'd938272;
    endcase
    return M2_W'(m) * M2_W'(m);
  endfunction

endpackage

// ===== hw/rtl/tof_pid_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with a tag riding along
`timescale 1ns / 1ps

module tof_pid_div #(
  parameter int unsigned NW = 61,
  parameter int unsigned DW = 28,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [NW-1:0] num_q [1:NW];
  logic [NW-1:0] quo_q [1:NW];
  logic [DW-1:0] rem_q [1:NW];
  logic [DW-1:0] den_q [1:NW];
  logic [TW-1:0] tag_q [1:NW];
  logic          vld_q [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_c;
    logic [NW-1:0] q_c;
    logic [DW-1:0] r_c;
    logic [DW-1:0] d_c;
    logic [TW-1:0] t_c;
    logic          v_c;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign n_c = num_i;
      assign q_c = '0;
      assign r_c = '0;
      assign d_c = den_i;
      assign t_c = tag_i;
      assign v_c = vld_i;
    end else begin : g_next
      assign n_c = num_q[k];
      assign q_c = quo_q[k];
      assign r_c = rem_q[k];
      assign d_c = den_q[k];
      assign t_c = tag_q[k];
      assign v_c = vld_q[k];
    end

    assign sh   = {r_c, n_c[NW-1]};
    assign ge   = sh >= {1'b0, d_c};
    assign diff = sh - {1'b0, d_c};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= {n_c[NW-2:0], 1'b0};
        quo_q[k+1] <= {q_c[NW-2:0], ge};
        rem_q[k+1] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        den_q[k+1] <= d_c;
        tag_q[k+1] <= t_c;
      end
    end
  end

  assign vld_o = vld_q[NW];
  assign quo_o = quo_q[NW];
  assign tag_o = tag_q[NW];

endmodule

// ===== hw/rtl/tof_pid_lane.sv =====
// one mass hypothesis: energy root, expected time, time error and the three sigma test
`timescale 1ns / 1ps

module tof_pid_lane #(
  parameter int unsigned MASS_IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  tof_pid_pkg::tof_ctx_t    ctx_i,
  input  logic [tof_pid_pkg::PK2_W-1:0] pk2_i,
  output logic                     vld_o,
  output logic                     hit_o,
  output logic                     gate_o,
  output logic                     ok_o
);

  import tof_pid_pkg::*;

  localparam logic [M2_W-1:0] M2 = mass_sq(MASS_IDX);
  localparam logic [Q4_W-1:0] SAT = '1;

  // stage a: m^2 + pk^2
  logic             va_q;
  logic [PK2_W-1:0] sv_q;
  tof_ctx_t         ca_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q <= PK2_W'(M2) + pk2_i;
      ca_q <= ctx_i;
    end
  end

  // integer square root, one root bit per stage
  logic [PK2_W-1:0] sqv_q [1:E_W];
  logic [E_W:0]     sqr_q [1:E_W];
  logic [E_W-1:0]   sqe_q [1:E_W];
  tof_ctx_t         sqc_q [1:E_W];
  logic             sqvl_q [1:E_W];

  for (genvar k = 0; k < E_W; k++) begin : g_sqrt
    logic [PK2_W-1:0] v_c;
    logic [E_W:0]     r_c;
    logic [E_W-1:0]   e_c;
    tof_ctx_t         c_c;
    logic             vl_c;
    logic [E_W+2:0]   sh;
    logic [E_W+2:0]   trial;
    logic [E_W+2:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_c  = sv_q;
      assign r_c  = '0;
      assign e_c  = '0;
      assign c_c  = ca_q;
      assign vl_c = va_q;
    end else begin : g_next
      assign v_c  = sqv_q[k];
      assign r_c  = sqr_q[k];
      assign e_c  = sqe_q[k];
      assign c_c  = sqc_q[k];
      assign vl_c = sqvl_q[k];
    end

    assign sh    = {r_c, v_c[PK2_W-1 -: 2]};
    assign trial = {1'b0, e_c, 2'b01};
    assign ge    = sh >= trial;
    assign diff  = sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqvl_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sqvl_q[k+1] <= vl_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sqv_q[k+1] <= {v_c[PK2_W-3:0], 2'b00};
        sqr_q[k+1] <= ge ? diff[E_W:0] : sh[E_W:0];
        sqe_q[k+1] <= {e_c[E_W-2:0], ge};
        sqc_q[k+1] <= c_c;
      end
    end
  end

  // stage b: t0 * e and e * pk
  logic                vb_q;
  logic [DIV_W-1:0]    te_q;
  logic [PK2_W-1:0]    epk_q;
  tof_ctx_t            cb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= sqvl_q[E_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      te_q  <= DIV_W'(sqc_q[E_W].t0) * DIV_W'(sqe_q[E_W]);
      epk_q <= PK2_W'(sqe_q[E_W]) * PK2_W'(sqc_q[E_W].pk);
      cb_q  <= sqc_q[E_W];
    end
  end

  // expected time and mass ratio dividers, same depth
  localparam int unsigned TG1_W = T0_W + 2 * P_W;
  localparam int unsigned TG2_W = TOF4_W + RES4_W + 2;
  localparam int unsigned TG3_W = TOF4_W + RES4_W + Q4_W + 2;

  logic             v1;
  logic [DIV_W-1:0] q1;
  logic [DIV_W-1:0] q2;
  logic [TG1_W-1:0] tg1;
  logic [TG2_W-1:0] tg2;

  tof_pid_div #(.NW(DIV_W), .DW(PK_W), .TW(TG1_W)) u_div_texp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vb_q),
    .num_i  (te_q),
    .den_i  (cb_q.pk),
    .tag_i  ({cb_q.t0, cb_q.ep, cb_q.p}),
    .vld_o  (v1),
    .quo_o  (q1),
    .tag_o  (tg1)
  );

  tof_pid_div #(.NW(DIV_W), .DW(PK2_W), .TW(TG2_W)) u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vb_q),
    .num_i  ({5'b0, M2, 16'b0}),
    .den_i  (epk_q),
    .tag_i  ({cb_q.tof4, cb_q.res4, cb_q.hit, cb_q.gate}),
    .vld_o  (),
    .quo_o  (q2),
    .tag_o  (tg2)
  );

  // stage c: saturate expected time, t0 * r16
  logic                vc_q;
  logic [Q4_W-1:0]     texp_c_q;
  logic [T0_W+R16_W-1:0] tr_q;
  logic [P_W-1:0]      ep_c_q;
  logic [P_W-1:0]      p_c_q;
  logic [TG2_W-1:0]    tg2_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      texp_c_q <= (|q1[DIV_W-1:Q4_W+12]) ? SAT : q1[Q4_W+11:12];
      tr_q     <= (T0_W+R16_W)'(tg1[TG1_W-1 -: T0_W]) * (T0_W+R16_W)'(q2[R16_W-1:0]);
      ep_c_q   <= tg1[2*P_W-1:P_W];
      p_c_q    <= tg1[P_W-1:0];
      tg2_c_q  <= tg2;
    end
  end

  // stage d: (t0 * r16 >> 16) * ep in two partial products
  localparam int unsigned A_W  = T0_W + R16_W - 16;
  localparam int unsigned LO_W = 22;
  localparam int unsigned HI_W = A_W - LO_W;

  logic                vd_q;
  logic [LO_W+P_W-1:0] lo_q;
  logic [HI_W+P_W-1:0] hi_q;
  logic [Q4_W-1:0]     texp_d_q;
  logic [P_W-1:0]      p_d_q;
  logic [TG2_W-1:0]    tg2_d_q;
  logic [A_W-1:0]      a_c;

  assign a_c = tr_q[T0_W+R16_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q     <= (LO_W+P_W)'(a_c[LO_W-1:0]) * (LO_W+P_W)'(ep_c_q);
      hi_q     <= (HI_W+P_W)'(a_c[A_W-1:LO_W]) * (HI_W+P_W)'(ep_c_q);
      texp_d_q <= texp_c_q;
      p_d_q    <= p_c_q;
      tg2_d_q  <= tg2_c_q;
    end
  end

  // stage e: combine partial products
  logic             ve_q;
  logic [DIV_W-1:0] n3_q;
  logic [Q4_W-1:0]  texp_e_q;
  logic [P_W-1:0]   p_e_q;
  logic [TG2_W-1:0] tg2_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_i) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n3_q     <= DIV_W'(lo_q) + {hi_q, {LO_W{1'b0}}};
      texp_e_q <= texp_d_q;
      p_e_q    <= p_d_q;
      tg2_e_q  <= tg2_d_q;
    end
  end

  // time error divider
  logic             v3;
  logic [DIV_W-1:0] q3;
  logic [TG3_W-1:0] tg3;

  tof_pid_div #(.NW(DIV_W), .DW(P_W), .TW(TG3_W)) u_div_err (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (ve_q),
    .num_i  (n3_q),
    .den_i  (p_e_q),
    .tag_i  ({tg2_e_q[TG2_W-1:2], texp_e_q, tg2_e_q[1:0]}),
    .vld_o  (v3),
    .quo_o  (q3),
    .tag_o  (tg3)
  );

  // stage f: squares
  logic [TOF4_W-1:0] tof4_f;
  logic [RES4_W-1:0] res4_f;
  logic [Q4_W-1:0]   texp_f;
  logic [Q4_W-1:0]   et4_f;
  logic [Q4_W-1:0]   d_f;

  assign tof4_f = tg3[TG3_W-1 -: TOF4_W];
  assign res4_f = tg3[TG3_W-TOF4_W-1 -: RES4_W];
  assign texp_f = tg3[Q4_W+1:2];
  assign et4_f  = (|q3[DIV_W-1:Q4_W+12]) ? SAT : q3[Q4_W+11:12];
  assign d_f    = (Q4_W'(tof4_f) >= texp_f) ? (Q4_W'(tof4_f) - texp_f)
                                            : (texp_f - Q4_W'(tof4_f));

  logic                vf_q;
  logic [2*Q4_W-1:0]   dd_q;
  logic [2*Q4_W-1:0]   ee_q;
  logic [2*RES4_W-1:0] rr_q;
  logic                hit_f_q;
  logic                gate_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q     <= (2*Q4_W)'(d_f) * (2*Q4_W)'(d_f);
      ee_q     <= (2*Q4_W)'(et4_f) * (2*Q4_W)'(et4_f);
      rr_q     <= (2*RES4_W)'(res4_f) * (2*RES4_W)'(res4_f);
      hit_f_q  <= tg3[1];
      gate_f_q <= tg3[0];
    end
  end

  // stage g: d^2 < 9 * sigma^2
  localparam int unsigned SG_W = 2 * Q4_W + 5;

  logic [SG_W-1:0] sig_c;
  logic [SG_W-1:0] sig9_c;
  logic            vg_q;
  logic            ok_q;
  logic            hit_g_q;
  logic            gate_g_q;

  assign sig_c  = SG_W'(ee_q) + SG_W'(rr_q);
  assign sig9_c = {sig_c[SG_W-4:0], 3'b000} + sig_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en_i) begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_q     <= SG_W'(dd_q) < sig9_c;
      hit_g_q  <= hit_f_q;
      gate_g_q <= gate_f_q;
    end
  end

  assign vld_o  = vg_q;
  assign hit_o  = hit_g_q;
  assign gate_o = gate_g_q;
  assign ok_o   = ok_q;

endmodule

// ===== hw/rtl/tof_mass_hypothesis_pid_core.sv =====
// top level: time-of-flight particle identification over mass hypotheses
`timescale 1ns / 1ps

//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    in_data_i  (tof_in_t)
//  out      output     out_valid_o / out_stall_i  out_data_o (tof_out_t)
//  cfg      input      apb psel/penable/pwrite    paddr, pwdata, prdata
//
//  one track transfer per cycle unless the output is held; each result runs through
//  the square root (28 stages) and two dividers of 61 stages in series in each lane
//  rst_ni clears all valid bits and loads the register reset values
//  a held output stalls the whole pipeline in place; nothing is dropped or repeated

module tof_mass_hypothesis_pid_core #(
  parameter int unsigned NUM_HYPOTHESES = tof_pid_pkg::NUM_HYPOTHESES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tof_pid_pkg::tof_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tof_pid_pkg::tof_out_t out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import tof_pid_pkg::*;

  localparam int unsigned LANES =
      (NUM_HYPOTHESES < MASS_COUNT) ? NUM_HYPOTHESES : MASS_COUNT;

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] rb_q, bhl_q, din_q, dout_q, dz_q;
  logic [RES_W-1:0] tres_q;
  tof_reg_e         reg_idx;

  assign reg_idx = tof_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q   <= 20'd100000;
      bhl_q  <= 20'd200000;
      din_q  <= 20'd50000;
      dout_q <= 20'd100000;
      dz_q   <= 20'd200000;
      tres_q <= 10'd20;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_BARREL_RADIUS: rb_q   <= pwdata[CFG_W-1:0];
        REG_BARREL_HALF:   bhl_q  <= pwdata[CFG_W-1:0];
        REG_DISC_INNER:    din_q  <= pwdata[CFG_W-1:0];
        REG_DISC_OUTER:    dout_q <= pwdata[CFG_W-1:0];
        REG_DISC_Z:        dz_q   <= pwdata[CFG_W-1:0];
        REG_TIME_RES:      tres_q <= pwdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BARREL_RADIUS: prdata = 32'(rb_q);
      REG_BARREL_HALF:   prdata = 32'(bhl_q);
      REG_DISC_INNER:    prdata = 32'(din_q);
      REG_DISC_OUTER:    prdata = 32'(dout_q);
      REG_DISC_Z:        prdata = 32'(dz_q);
      REG_TIME_RES:      prdata = 32'(tres_q);
      default:           prdata = '0;
    endcase
  end

  // squared geometry limits, refreshed each cycle (user moves config only while idle)
  logic [R2_W-1:0] rlo2_q, rhi2_q, din2_q, dout2_q;
  logic [CFG_W-1:0] rbm1;
  logic [CFG_W:0]   rbp1;

  assign rbm1 = rb_q - 1'b1;
  assign rbp1 = {1'b0, rb_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    rlo2_q  <= R2_W'(rbm1) * R2_W'(rbm1);
    rhi2_q  <= R2_W'(rbp1) * R2_W'(rbp1);
    din2_q  <= R2_W'(din_q) * R2_W'(din_q);
    dout2_q <= R2_W'(dout_q) * R2_W'(dout_q);
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_vld_q;

  // every stage moves together unless a finished result is held
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage 1: magnitudes and first products ----------------
  logic [POS_W-1:0] ax, ay, az;

  function automatic logic [POS_W-1:0] mag(input logic [POS_W-1:0] v);
    return v[POS_W-1] ? (POS_W'(0) - v) : v;
  endfunction

  assign ax = mag(in_data_i.x_outer);
  assign ay = mag(in_data_i.y_outer);
  assign az = mag(in_data_i.z_outer);

  logic                  v1_q;
  logic [R2_W-2:0]       ax2_q, ay2_q;
  logic [POS_W-1:0]      az1_q;
  logic [TOF4_W-1:0]     tof4_1_q;
  logic [LEN_W+27:0]     lt_q;
  logic [PK_W-1:0]       pk1_q;
  logic [P_W-1:0]        p1_q, ep1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q    <= (R2_W-1)'(ax) * (R2_W-1)'(ax);
      ay2_q    <= (R2_W-1)'(ay) * (R2_W-1)'(ay);
      az1_q    <= az;
      tof4_1_q <= {in_data_i.hit_time, 4'b0000};
      lt_q     <= (LEN_W+28)'(in_data_i.path_length) * (LEN_W+28)'(INV_C_Q32);
      pk1_q    <= PK_W'(in_data_i.momentum) * PK_W'(PK_SCALE);
      p1_q     <= in_data_i.momentum;
      ep1_q    <= in_data_i.momentum_error;
    end
  end

  // ---------------- stage 2: radius squared, light time, pk squared ----------------
  logic              v2_q;
  logic [R2_W-1:0]   r2_q;
  logic [POS_W-1:0]  az2_q;
  logic [T0_W-1:0]   t0_2_q;
  logic [PK2_W-1:0]  pk2_2_q;
  logic [PK_W-1:0]   pk2s_q;
  logic [TOF4_W-1:0] tof4_2_q;
  logic [P_W-1:0]    p2_q, ep2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q     <= R2_W'(ax2_q) + R2_W'(ay2_q);
      az2_q    <= az1_q;
      t0_2_q   <= lt_q[LEN_W+27:16];
      pk2_2_q  <= PK2_W'(pk1_q) * PK2_W'(pk1_q);
      pk2s_q   <= pk1_q;
      tof4_2_q <= tof4_1_q;
      p2_q     <= p1_q;
      ep2_q    <= ep1_q;
    end
  end

  // ---------------- stage 3: geometry match ----------------
  logic barrel_c, disc_c, hit_c;

  assign barrel_c = ((rb_q == '0) || (r2_q > rlo2_q)) && (r2_q < rhi2_q) &&
                    (az2_q < POS_W'(bhl_q));
  assign disc_c   = (r2_q > din2_q) && (r2_q < dout2_q) && (az2_q == POS_W'(dz_q));
  assign hit_c    = barrel_c || disc_c;

  logic             v3_q;
  tof_ctx_t         ctx_q;
  logic [PK2_W-1:0] pk2_3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q.pk   <= pk2s_q;
      ctx_q.t0   <= t0_2_q;
      ctx_q.p    <= p2_q;
      ctx_q.ep   <= ep2_q;
      ctx_q.tof4 <= tof4_2_q;
      ctx_q.res4 <= {tres_q, 4'b0000};
      ctx_q.hit  <= hit_c;
      // no hit or zero momentum gives an empty mask
      ctx_q.gate <= hit_c && (p2_q != '0);
      pk2_3_q    <= pk2_2_q;
    end
  end

  // ---------------- hypothesis lanes ----------------
  logic lane_vld  [LANES];
  logic lane_hit  [LANES];
  logic lane_gate [LANES];
  logic lane_ok   [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tof_pid_lane #(.MASS_IDX(i)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (v3_q),
      .ctx_i  (ctx_q),
      .pk2_i  (pk2_3_q),
      .vld_o  (lane_vld[i]),
      .hit_o  (lane_hit[i]),
      .gate_o (lane_gate[i]),
      .ok_o   (lane_ok[i])
    );
  end

  logic [MASK_W-1:0] mask_c;

  always_comb begin
    for (int unsigned b = 0; b < MASK_W; b++) begin
      if (b < LANES) begin
        mask_c[b] = lane_ok[b] && lane_gate[b];
      end else begin
        mask_c[b] = 1'b0;
      end
    end
  end

  // ---------------- output register ----------------
  tof_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= lane_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.has_hit  <= lane_hit[0];
      out_q.pid_mask <= mask_c;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tof_pid_scoreboard.sv =====
// scoreboard: time-of-flight pid predictor and queue of expected results
`timescale 1ns / 1ps

class tof_pid_scoreboard;
  localparam longint unsigned INV_C = 64'd143264688;
  localparam longint unsigned Q4_MAX = (64'd1 << 29) - 64'd1;

  longint unsigned mass_kev[5] = '{64'd511, 64'd105658, 64'd139570, 64'd493677, 64'd938272};
  int unsigned hyp_count;

  longint unsigned radius, half_len, din, dout, disc_z, tres;
  tof_pid_pkg::tof_out_t pending[$];
  int unsigned errors;

  function new(int unsigned n);
    hyp_count = n;
    errors = 0;
    load_defaults();
  endfunction

  function void load_defaults();
    radius = 100000; half_len = 200000; din = 50000;
    dout = 100000; disc_z = 200000; tres = 20;
  endfunction

  function void write_reg(int unsigned idx, longint unsigned v);
    case (idx)
      tof_pid_pkg::REG_BARREL_RADIUS: radius = v & 64'hFFFFF;
      tof_pid_pkg::REG_BARREL_HALF:   half_len = v & 64'hFFFFF;
      tof_pid_pkg::REG_DISC_INNER:    din = v & 64'hFFFFF;
      tof_pid_pkg::REG_DISC_OUTER:    dout = v & 64'hFFFFF;
      tof_pid_pkg::REG_DISC_Z:        disc_z = v & 64'hFFFFF;
      tof_pid_pkg::REG_TIME_RES:      tres = v & 64'h3FF;
      default: ;
    endcase
  endfunction

  function longint unsigned magnitude(logic [20:0] v);
    if (v[20]) return 64'h200000 - longint'(v);
    return longint'(v);
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // expected arrival in q4 ps for one mass (unsaturated is fine for stimulus)
  function longint unsigned expected_time4(int idx, longint unsigned len, longint unsigned p);
    longint unsigned pk, en, t0;
    pk = p * 1000;
    en = int_sqrt(mass_kev[idx] * mass_kev[idx] + pk * pk);
    t0 = (len * INV_C) >> 16;
    return ((t0 * en) / pk) >> 12;
  endfunction

  function void note_track(tof_pid_pkg::tof_in_t t);
    longint unsigned ax, ay, az, r2, p, ep, len, tof4, res4, pk, t0, m2, en;
    longint unsigned texp4, r16, et4, d;
    logic hit;
    tof_pid_pkg::tof_out_t o;
    ax = magnitude(t.x_outer);
    ay = magnitude(t.y_outer);
    az = magnitude(t.z_outer);
    r2 = ax * ax + ay * ay;
    p = t.momentum; ep = t.momentum_error; len = t.path_length;
    tof4 = longint'(t.hit_time) << 4;
    res4 = tres << 4;
    hit = 0;
    if ((radius == 0 || r2 > (radius - 1) * (radius - 1)) &&
        r2 < (radius + 1) * (radius + 1) && az < half_len)
      hit = 1;
    else if (r2 > din * din && r2 < dout * dout && az == disc_z)
      hit = 1;
    o.has_hit = hit;
    o.pid_mask = '0;
    if (hit && p != 0) begin
      pk = p * 1000;
      t0 = (len * INV_C) >> 16;
      for (int i = 0; i < 5 && i < hyp_count; i++) begin
        m2 = mass_kev[i] * mass_kev[i];
        en = int_sqrt(m2 + pk * pk);
        texp4 = ((t0 * en) / pk) >> 12;
        r16 = (m2 << 16) / (en * pk);
        et4 = ((((t0 * r16) >> 16) * ep) / p) >> 12;
        if (texp4 > Q4_MAX) texp4 = Q4_MAX;
        if (et4 > Q4_MAX) et4 = Q4_MAX;
        d = (tof4 >= texp4) ? tof4 - texp4 : texp4 - tof4;
        if (d * d < 9 * (et4 * et4 + res4 * res4)) o.pid_mask[i] = 1'b1;
      end
    end
    pending.insert(pending.size(), o);
  endfunction

  function void check_result(tof_pid_pkg::tof_out_t got);
    tof_pid_pkg::tof_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result hit=%0d mask=%b", $time, got.has_hit, got.pid_mask);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.has_hit !== want.has_hit) begin
      $display("%0t: has_hit expected %0d actual %0d", $time, want.has_hit, got.has_hit);
      errors++;
    end
    if (got.pid_mask !== want.pid_mask) begin
      $display("%0t: pid_mask expected %b actual %b", $time, want.pid_mask, got.pid_mask);
      errors++;
    end
  endfunction
endclass

// ===== verif/testbench.sv =====
// testbench top: drives tracks and register writes into the tof pid core
`timescale 1ns / 1ps

module testbench;
  import tof_pid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PIPE_DRAIN = 200;   // above the pipeline latency
  localparam int unsigned UNUSED_REG_IDX = 7;
  localparam int unsigned TRACKS_PER_PHASE = 170;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tof_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tof_out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // idle percentages for sender and receiver, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;

  tof_pid_scoreboard pid_sb = new(NUM_HYPOTHESES_DEF);

  tof_mass_hypothesis_pid_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  // run limit in case the pipeline hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // accepted track transfer: predict its result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) pid_sb.note_track(in_data_i);
  end

  // accepted result transfer: compare with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) pid_sb.check_result(out_data_o);
  end

  // receiver back-pressure, one decision per cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // apb write: setup cycle, then access cycle completes at the next rising edge
  task automatic reg_write(int unsigned idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 4); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pid_sb.write_reg(idx, val);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until every prediction has been matched, then let the pipe settle
  task automatic drain();
    while (pid_sb.pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic load_config(logic [19:0] rb, logic [19:0] hl, logic [19:0] di,
                             logic [19:0] dq, logic [19:0] dz, logic [9:0] tr);
    reg_write(REG_BARREL_RADIUS, 32'(rb));
    reg_write(REG_BARREL_HALF, 32'(hl));
    reg_write(REG_DISC_INNER, 32'(di));
    reg_write(REG_DISC_OUTER, 32'(dq));
    reg_write(REG_DISC_Z, 32'(dz));
    reg_write(REG_TIME_RES, 32'(tr));
  endtask

  // one track transfer; called at a falling edge, returns at a falling edge
  task automatic send_track(tof_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // two's complement helper for positions
  function automatic logic [20:0] signed_pos(longint unsigned mag, bit neg);
    return neg ? 21'(-mag) : 21'(mag);
  endfunction

  // mostly tracks that land on a detector surface with a plausible time
  function automatic tof_in_t make_track();
    tof_in_t t;
    longint unsigned mag, texp, spread, tm;
    int hyp;
    t.x_outer = 21'($urandom); t.y_outer = 21'($urandom); t.z_outer = 21'($urandom);
    t.hit_time = 20'($urandom); t.path_length = 21'($urandom);
    t.momentum = 18'($urandom); t.momentum_error = 18'($urandom);
    if ($urandom_range(99) < 20) return t;
    if ($urandom_range(1)) begin
      // barrel surface on one of the axes
      mag = pid_sb.radius;
      case ($urandom_range(3))
        0: begin t.x_outer = signed_pos(mag, 0); t.y_outer = '0; end
        1: begin t.x_outer = signed_pos(mag, 1); t.y_outer = '0; end
        2: begin t.x_outer = '0; t.y_outer = signed_pos(mag, 0); end
        default: begin t.x_outer = '0; t.y_outer = signed_pos(mag, 1); end
      endcase
      mag = (pid_sb.half_len > 0) ? $urandom_range(pid_sb.half_len - 1) : 0;
      t.z_outer = signed_pos(mag, $urandom_range(1));
    end else if (pid_sb.dout > pid_sb.din + 1) begin
      mag = $urandom_range(pid_sb.dout - 1, pid_sb.din + 1);
      t.x_outer = signed_pos(mag, $urandom_range(1));
      t.y_outer = '0;
      t.z_outer = signed_pos(pid_sb.disc_z, $urandom_range(1));
    end
    // keep momenta and paths mostly moderate, some of full range
    if ($urandom_range(3) != 0) begin
      t.momentum = 18'($urandom_range(5000, 1));
      t.path_length = 21'($urandom_range(400000));
      t.momentum_error = 18'($urandom_range(t.momentum / 10));
    end
    if (t.momentum != 0 && $urandom_range(3) != 0) begin
      hyp = $urandom_range(4);
      texp = pid_sb.expected_time4(hyp, t.path_length, t.momentum) >> 4;
      spread = 3 * pid_sb.tres + 4;
      tm = texp + $urandom_range(2 * spread);
      tm = (tm > spread) ? tm - spread : 0;
      t.hit_time = (tm > 64'hFFFFF) ? 20'hFFFFF : 20'(tm);
    end
    return t;
  endfunction

  // directed track from explicit values
  function automatic tof_in_t track_of(logic [20:0] x, logic [20:0] y, logic [20:0] z,
                                       logic [19:0] tm, logic [20:0] len,
                                       logic [17:0] p, logic [17:0] ep);
    tof_in_t t;
    t.x_outer = x; t.y_outer = y; t.z_outer = z; t.hit_time = tm;
    t.path_length = len; t.momentum = p; t.momentum_error = ep;
    return t;
  endfunction

  initial begin
    tof_in_t t;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed tracks under reset register values
    send_track(track_of(21'd100000, 0, 0, 20'd3336, 21'd100000, 18'd1000, 18'd10));
    send_track(track_of(0, -21'sd100000, 21'd199999, 20'd7000, 21'd200000, 18'd500, 18'd5));
    send_track(track_of(21'd100000, 0, 0, 20'd3336, 21'd100000, 18'd0, 18'd10)); // zero p
    send_track(track_of(21'd75000, 0, 21'd200000, 20'd6700, 21'd200000, 18'd2000, 0));
    send_track(track_of(-21'sd75000, 0, -21'sd200000, 20'd6700, 21'd200000, 18'd300, 18'd30));
    send_track(track_of(21'd75000, 0, 21'd199999, 20'd6700, 21'd200000, 18'd300, 0)); // no hit
    send_track(track_of(21'h100000, 21'h100000, 21'h100000, 20'hFFFFF, 21'h1FFFFF,
                        18'h3FFFF, 18'h3FFFF));
    send_track(track_of(21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF, 0, 0, 18'd1, 0));
    // saturating expected time: long path, tiny momentum, proton
    send_track(track_of(21'd100000, 0, 0, 20'hFFFFF, 21'h1FFFFF, 18'd1, 18'h3FFFF));
    send_track(track_of(21'd100000, 0, 0, 0, 21'h1FFFFF, 18'd1, 18'd1));
    send_track(track_of(21'd100001, 0, 0, 20'd3336, 21'd100000, 18'd1000, 0));
    send_track(track_of(21'd99999, 0, 0, 20'd3336, 21'd100000, 18'd1000, 0));
    send_track(track_of(21'd100000, 0, 21'd200000, 20'd3336, 21'd100000, 18'd1000, 0));
    for (int k = 0; k < 8; k++) send_track(make_track());
    in_valid_i <= 1'b0;
    drain();

    // zero sigma: no resolution and no momentum error accepts nothing
    reg_write(REG_TIME_RES, 32'd0);
    reg_write(UNUSED_REG_IDX, 32'hFFFFFFFF);   // must be ignored
    @(negedge clk_i);
    send_track(track_of(21'd100000, 0, 0, 20'd3335, 21'd100000, 18'h3FFFF, 0));
    send_track(track_of(21'd100000, 0, 0, 20'd3336, 21'd100000, 18'h3FFFF, 0));
    in_valid_i <= 1'b0;
    drain();

    // random phases: register settings and idling profiles vary together
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_config(20'd100000, 20'd200000, 20'd50000, 20'd100000, 20'd200000, 10'd20);
        1: load_config(20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'hFFFFF, 10'h3FF);
        2: load_config(20'd0, 20'd1, 20'd0, 20'd2, 20'd0, 10'd0);
        3: load_config(20'($urandom_range(200000)), 20'($urandom), 20'($urandom_range(50000)),
                       20'($urandom_range(300000, 60000)), 20'($urandom), 10'($urandom));
        4: load_config(20'd50000, 20'd80000, 20'd10000, 20'd60000, 20'd80000, 10'd0);
        default: load_config(20'($urandom), 20'($urandom), 20'($urandom_range(100000)),
                             20'($urandom), 20'($urandom), 10'($urandom_range(100)));
      endcase
      @(negedge clk_i);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int k = 0; k < TRACKS_PER_PHASE; k++) begin
        t = make_track();
        send_track(t);
      end
      in_valid_i <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (pid_sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
